// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/cbb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular byte buffer package
// Field widths, operation codes and the controller command bundle.
// ----------------------------------------------------------------------------
package cbb_pkg;

  localparam int unsigned DEPTH_DEF = 4096;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned LEN_W  = 13;

  localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DISCARD = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ADVANCE = 3'd4;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

// ----- hw/rtl/cbb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular byte buffer controller
// Sequences capture, execute and respond for one beat at a time.
// ----------------------------------------------------------------------------
module cbb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output cbb_pkg::cmd_t cmd
);
  import cbb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_RESP);
  assign cmd.load  = in_valid && (state == S_IDLE);
  assign cmd.exec  = (state == S_EXEC);

endmodule

// ----- hw/rtl/cbb_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular byte buffer datapath
// Byte store, read and write pointers, fill count and result registers.
// ----------------------------------------------------------------------------
module cbb_datapath #(
  parameter int unsigned DEPTH = cbb_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cbb_pkg::cmd_t               cmd,
  input  logic [cbb_pkg::MODE_W-1:0]  mode,
  input  logic [cbb_pkg::DATA_W-1:0]  data_in,
  input  logic [cbb_pkg::LEN_W-1:0]   length,
  output logic [cbb_pkg::DATA_W-1:0]  data_out,
  output logic [cbb_pkg::LEN_W-1:0]   moved,
  output logic [cbb_pkg::LEN_W-1:0]   used_len,
  output logic [cbb_pkg::LEN_W-1:0]   free_len,
  output logic                        ok
);
  import cbb_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned XW = (CW > LEN_W) ? CW : LEN_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;

  logic [MODE_W-1:0] op_mode;
  logic [DATA_W-1:0] op_data;
  logic [LEN_W-1:0]  op_len;

  logic [PW-1:0] rp;
  logic [PW-1:0] rp_next;
  logic [PW-1:0] wp;
  logic [PW-1:0] wp_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic [LEN_W-1:0] res_moved;
  logic [LEN_W-1:0] moved_next;
  logic             res_ok;
  logic             ok_next;
  logic             res_hit;
  logic             hit_next;

  logic          we;
  logic [PW-1:0] waddr;
  logic [PW-1:0] raddr;
  logic          empty;
  logic          full;
  logic [XW-1:0] len_x;
  logic [XW-1:0] cnt_x;
  logic [CW-1:0] room;
  logic [XW-1:0] room_x;
  logic [XW-1:0] adv_n;
  logic [PW-1:0] adv_base;
  logic [PW-1:0] off_ptr;
  logic [PW-1:0] adv_ptr;
  logic [XW-1:0] used_x;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(DEPTH - 1)) r = '0;
    else r = p + PW'(1);
    return r;
  endfunction

  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [CW-1:0] n);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(n);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[PW-1:0];
  endfunction

  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));
  assign len_x    = XW'(op_len);
  assign cnt_x    = XW'(count);
  assign room     = CW'(DEPTH) - count;
  assign room_x   = XW'(room);
  assign adv_n    = (len_x < room_x) ? len_x : room_x;
  assign adv_base = empty ? '0 : wp;
  assign off_ptr  = ptr_add(rp, len_x[CW-1:0]);
  assign adv_ptr  = ptr_add(adv_base, adv_n[CW-1:0]);

  always_comb begin
    rp_next    = rp;
    wp_next    = wp;
    count_next = count;
    moved_next = '0;
    ok_next    = 1'b0;
    hit_next   = 1'b0;
    we         = 1'b0;
    waddr      = wp;
    raddr      = rp;
    case (op_mode)
      MODE_WRITE: begin
        if (!full) begin
          we         = 1'b1;
          waddr      = adv_base;
          wp_next    = ptr_inc(adv_base);
          rp_next    = empty ? '0 : rp;
          count_next = count + CW'(1);
          moved_next = LEN_W'(1);
          ok_next    = 1'b1;
        end
      end
      MODE_POP: begin
        if (!empty) begin
          hit_next   = 1'b1;
          count_next = count - CW'(1);
          if (count == CW'(1)) begin
            rp_next = '0;
            wp_next = '0;
          end else begin
            rp_next = ptr_inc(rp);
          end
          moved_next = LEN_W'(1);
          ok_next    = 1'b1;
        end
      end
      MODE_PEEK: begin
        if (len_x < cnt_x) begin
          raddr    = off_ptr;
          hit_next = 1'b1;
          ok_next  = 1'b1;
        end
      end
      MODE_DISCARD: begin
        if (op_len == '0) begin
          rp_next    = '0;
          wp_next    = '0;
          count_next = '0;
          ok_next    = 1'b1;
        end else if (!empty) begin
          if (cnt_x <= len_x) begin
            rp_next    = '0;
            wp_next    = '0;
            count_next = '0;
            moved_next = cnt_x[LEN_W-1:0];
            ok_next    = (cnt_x == len_x);
          end else begin
            rp_next    = off_ptr;
            count_next = count - len_x[CW-1:0];
            moved_next = op_len;
            ok_next    = 1'b1;
          end
        end
      end
      MODE_ADVANCE: begin
        if (!full) begin
          rp_next    = empty ? '0 : rp;
          wp_next    = adv_ptr;
          count_next = count + adv_n[CW-1:0];
          moved_next = adv_n[LEN_W-1:0];
          ok_next    = (adv_n == len_x);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode <= mode;
      op_data <= data_in;
      op_len  <= length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp    <= '0;
      wp    <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      rp    <= rp_next;
      wp    <= wp_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_moved <= moved_next;
      res_ok    <= ok_next;
      res_hit   <= hit_next;
    end
  end

  // byte store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && we) mem[waddr] <= op_data;
    if (cmd.exec && hit_next) rdata <= mem[raddr];
  end

  assign used_x   = XW'(count);
  assign data_out = res_hit ? rdata : '0;
  assign moved    = res_moved;
  assign ok       = res_ok;
  assign used_len = used_x[LEN_W-1:0];
  assign free_len = room_x[LEN_W-1:0];

endmodule

// ----- hw/rtl/circular_byte_buffer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular byte buffer unit
// Byte ring buffer with write, pop, peek, discard and write-advance beats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one operation per beat:
//   mode, data_in and length. Output channel (out_valid / out_ready)
//   returns exactly one result beat per input beat: data_out, moved,
//   used_len, free_len and ok.
//   Result path: the input beat is captured in the idle state, the store is
//   read or written in the execute state, and the result beat is offered in
//   the respond state. One operation is in flight at a time: capture,
//   execute and result steps are set by the three controller states, and no
//   new input beat is taken until the result beat is accepted.
//   Stall: while out_ready is low the result beat is held unchanged and
//   in_ready stays low; no state changes.
//   Reset: read and write pointers and the fill count clear to zero, so
//   the buffer is empty at once; byte contents are not cleared and there
//   is no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circular_byte_buffer_unit #(
  parameter int unsigned DEPTH = cbb_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cbb_pkg::MODE_W-1:0]  mode,
  input  logic [cbb_pkg::DATA_W-1:0]  data_in,
  input  logic [cbb_pkg::LEN_W-1:0]   length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cbb_pkg::DATA_W-1:0]  data_out,
  output logic [cbb_pkg::LEN_W-1:0]   moved,
  output logic [cbb_pkg::LEN_W-1:0]   used_len,
  output logic [cbb_pkg::LEN_W-1:0]   free_len,
  output logic                        ok
);
  import cbb_pkg::*;

  cmd_t cmd;

  cbb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cbb_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .mode     (mode),
    .data_in  (data_in),
    .length   (length),
    .data_out (data_out),
    .moved    (moved),
    .used_len (used_len),
    .free_len (free_len),
    .ok       (ok)
  );

  `ASSERT_ALWAYS(a_one_side, clk, rst, !(in_ready && out_valid), "ready and result both up")
  `ASSERT_NEXT(a_load_exec, clk, rst, cmd.load, cmd.exec && !out_valid, "no execute after capture")
  `ASSERT_NEXT(a_exec_resp, clk, rst, cmd.exec, out_valid, "no result after execute")
  `ASSERT_SAME(a_data_ok, clk, rst, out_valid && (data_out != '0), ok, "data without success")

endmodule

// ----- sim/circular_byte_buffer_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular byte buffer unit test
// Drives write, pop, peek, discard, write-advance and unused-mode beats into
// the ring buffer with random gaps on both channels. A scoreboard keeps its
// own copy of the pointers, full flag and byte store, predicts every result
// beat and compares it field by field. Pops and peeks never land on an entry
// that was skipped by an advance and never written.
// ----------------------------------------------------------------------------
module circular_byte_buffer_unit_test;
  import cbb_pkg::*;

  localparam int unsigned RING_DEPTH = DEPTH_DEF;
  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int TOTAL_ITEMS = 676;
  localparam int DRAIN_AT = 350;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  moved;
    logic [LEN_W-1:0]  used;
    logic [LEN_W-1:0]  free;
    logic              ok;
  } ring_result_t;

  class ring_scoreboard;
    logic [DATA_W-1:0] store [RING_DEPTH];
    bit                written [RING_DEPTH];
    logic [PTR_W-1:0]  rd_ptr;
    logic [PTR_W-1:0]  wr_ptr;
    bit                full;
    ring_result_t      expected_q [$];
    int                errors;

    function new();
      rd_ptr = '0;
      wr_ptr = '0;
      full   = 1'b0;
      errors = 0;
    endfunction

    function void clear_ptrs();
      rd_ptr = '0;
      wr_ptr = '0;
      full   = 1'b0;
    endfunction

    function logic [LEN_W-1:0] fill();
      logic [PTR_W-1:0] diff;
      diff = wr_ptr - rd_ptr;
      if (full) return LEN_W'(RING_DEPTH);
      return LEN_W'(diff);
    endfunction

    function bit entry_written(logic [LEN_W-1:0] off);
      logic [PTR_W-1:0] idx;
      idx = rd_ptr + off[PTR_W-1:0];
      return written[idx];
    endfunction

    // length of the never-written stretch at the head of the data
    function logic [LEN_W-1:0] blank_run();
      logic [LEN_W-1:0] n;
      logic [LEN_W-1:0] lim;
      n = '0;
      lim = fill();
      while (n < lim && !entry_written(n)) n++;
      return n;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [MODE_W-1:0] op, logic [DATA_W-1:0] din,
                             logic [LEN_W-1:0] len);
      ring_result_t     r;
      logic [LEN_W-1:0] level;
      logic [LEN_W-1:0] n;
      logic [PTR_W-1:0] idx;
      r = '0;
      level = fill();
      case (op)
        MODE_WRITE: begin
          if (level == 0) clear_ptrs();
          if (!full) begin
            store[wr_ptr] = din;
            written[wr_ptr] = 1'b1;
            wr_ptr = wr_ptr + 1'b1;
            if (wr_ptr == rd_ptr) full = 1'b1;
            r.moved = 1;
            r.ok = 1'b1;
          end
        end
        MODE_POP: begin
          if (level != 0) begin
            r.data = store[rd_ptr];
            rd_ptr = rd_ptr + 1'b1;
            full = 1'b0;
            if (rd_ptr == wr_ptr) clear_ptrs();
            r.moved = 1;
            r.ok = 1'b1;
          end
        end
        MODE_PEEK: begin
          if (len < level) begin
            idx = rd_ptr + len[PTR_W-1:0];
            r.data = store[idx];
            r.ok = 1'b1;
          end
        end
        MODE_DISCARD: begin
          if (len == 0) begin
            clear_ptrs();
            r.ok = 1'b1;
          end else if (level != 0) begin
            if (level <= len) begin
              clear_ptrs();
              r.moved = level;
            end else begin
              rd_ptr = rd_ptr + len[PTR_W-1:0];
              full = 1'b0;
              r.moved = len;
            end
            r.ok = (r.moved == len);
          end
        end
        MODE_ADVANCE: begin
          if (!full) begin
            if (level == 0) clear_ptrs();
            n = LEN_W'(RING_DEPTH) - level;
            if (len < n) n = len;
            wr_ptr = wr_ptr + n[PTR_W-1:0];
            if (n != 0 && wr_ptr == rd_ptr) full = 1'b1;
            r.moved = n;
            r.ok = (n == len);
          end
        end
        default: ;
      endcase
      r.used = fill();
      r.free = LEN_W'(RING_DEPTH) - r.used;
      expected_q.push_back(r);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, actual used_len %0d", $time, got.used);
        return;
      end
      want = expected_q.pop_front();
      compare("data_out", want.data, got.data);
      compare("moved", want.moved, got.moved);
      compare("used_len", want.used, got.used);
      compare("free_len", want.free, got.free);
      compare("ok", want.ok, got.ok);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [MODE_W-1:0] mode = '0;
  logic [DATA_W-1:0] data_in = '0;
  logic [LEN_W-1:0]  length = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] data_out;
  logic [LEN_W-1:0]  moved;
  logic [LEN_W-1:0]  used_len;
  logic [LEN_W-1:0]  free_len;
  logic              ok;

  ring_scoreboard board;
  int items_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;

  circular_byte_buffer_unit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // alternating stretches of back-to-back beats and random gaps
  function automatic int draw_gap(int idx, int period);
    if ((idx / period) % 3 == 1) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic send_op(logic [MODE_W-1:0] m, logic [DATA_W-1:0] d, logic [LEN_W-1:0] l);
    int gap;
    gap = draw_gap(items_sent, 64);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    data_in <= d;
    length <= l;
    do @(posedge clk); while (!in_ready);
    board.note_input(m, d, l);
    items_sent++;
  endtask

  task automatic random_op();
    logic [MODE_W-1:0] m;
    logic [DATA_W-1:0] d;
    logic [LEN_W-1:0]  l;
    logic [LEN_W-1:0]  level;
    logic [LEN_W-1:0]  room;
    int pick;
    level = board.fill();
    room = LEN_W'(RING_DEPTH) - level;
    d = DATA_W'($urandom);
    l = LEN_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 34) begin
      m = MODE_WRITE;
    end else if (pick < 54) begin
      m = MODE_POP;
      if (level != 0 && !board.entry_written(0)) begin
        m = MODE_DISCARD;
        l = board.blank_run();
      end
    end else if (pick < 69) begin
      m = MODE_PEEK;
      case ($urandom_range(0, 3))
        0: l = (level == 0) ? '0 : LEN_W'($urandom_range(0, (level > 16) ? 15 : level - 1));
        1: l = (level == 0) ? '0 : LEN_W'($urandom_range(0, level - 1));
        2: l = level + LEN_W'($urandom_range(0, 3));
        default: ;
      endcase
      if (l < level && !board.entry_written(l)) l = level;
    end else if (pick < 79) begin
      m = MODE_DISCARD;
      case ($urandom_range(0, 9))
        0: l = '0;
        1: ;
        2: l = level;
        default: l = LEN_W'($urandom_range(1, 8));
      endcase
    end else if (pick < 89) begin
      m = MODE_ADVANCE;
      case ($urandom_range(0, 9))
        0: l = '0;
        1: ;
        2: l = room;
        3: l = room + 1'b1;
        default: l = LEN_W'($urandom_range(1, 8));
      endcase
    end else if (pick < 93) begin
      m = MODE_W'($urandom_range(MODE_ADVANCE + 1, 2 ** MODE_W - 1));
    end else begin
      // push the pointers to an arbitrary spot, leaving a few skipped bytes
      l = (room > 12) ? room - LEN_W'($urandom_range(0, 12)) : room;
      send_op(MODE_ADVANCE, d, l);
      level = board.fill();
      m = MODE_DISCARD;
      l = (level > 4) ? level - LEN_W'($urandom_range(0, 4)) : level;
    end
    send_op(m, d, l);
  endtask

  initial begin
    wait (!rst);
    forever begin
      int gap;
      gap = draw_gap(results_seen, 48);
      if (results_seen == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result('{data_out, moved, used_len, free_len, ok});
      results_seen++;
    end
  end

  initial begin
    bit drained;
    drained = 1'b0;
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_op(MODE_POP, 8'h00, 13'd0);
    send_op(MODE_DISCARD, 8'h00, 13'd5);
    send_op(MODE_WRITE, 8'h00, 13'd0);
    send_op(MODE_WRITE, 8'hFF, 13'd0);
    send_op(MODE_WRITE, 8'hA5, 13'd0);
    send_op(MODE_PEEK, 8'h00, 13'd0);
    send_op(MODE_PEEK, 8'h00, 13'd2);
    send_op(MODE_PEEK, 8'h00, 13'd3);
    send_op(MODE_POP, 8'h00, 13'd0);
    send_op(MODE_DISCARD, 8'h00, 13'd0);
    send_op(MODE_ADVANCE, 8'h00, 13'd0);
    send_op(MODE_WRITE, 8'h5A, 13'd0);
    send_op(MODE_ADVANCE, 8'h00, 13'd4095);
    send_op(MODE_WRITE, 8'h77, 13'd0);
    send_op(MODE_ADVANCE, 8'h00, 13'd0);
    send_op(MODE_PEEK, 8'h00, 13'd4096);
    send_op(MODE_POP, 8'h00, 13'd0);
    send_op(MODE_DISCARD, 8'h00, 13'h1FFF);
    send_op(MODE_ADVANCE, 8'h00, 13'h1FFF);
    send_op(MODE_PEEK, 8'h00, 13'h1FFF);
    send_op(MODE_DISCARD, 8'h00, 13'd4096);
    for (int m = MODE_ADVANCE + 1; m < 2 ** MODE_W; m++) begin
      send_op(MODE_W'(m), 8'hFF, 13'h1FFF);
    end
    send_op(MODE_WRITE, 8'hC3, 13'd0);
    send_op(MODE_DISCARD, 8'h00, 13'd3);

    while (items_sent < TOTAL_ITEMS) begin
      if (!drained && items_sent >= DRAIN_AT) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
      end
      random_op();
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
